// File: rtl/core/comment_stripping_tokenizer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the comment stripping tokenizer
// Concurrent checks sampled on aclk and held off while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef COMMENT_STRIPPING_TOKENIZER_ASSERT_SVH
`define COMMENT_STRIPPING_TOKENIZER_ASSERT_SVH

// The condition must hold at every clock edge out of reset.
`define CST_ASSERT(label, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("tokenizer check failed");

// When the trigger holds, the result must hold in the following cycle.
`define CST_ASSERT_NEXT(label, trig, res) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (res)) \
        else $error("tokenizer sequence check failed");

`endif

// File: rtl/core/cst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_pkg
// Character codes, types and the per-character step function of the tokenizer;
// the bundle type is shared by the front end, result queue and output stage.
// ----------------------------------------------------------------------------
package cst_pkg;

    // Character codes.
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;

    // Result queue depth, in bundles.
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // Lexer state carried from one character to the next.
    typedef struct packed {
        logic [7:0] held_char;
        logic       held_valid;
        logic       in_line;
        logic       in_block;
        logic       skip;
    } tok_state_t;

    // Outcome of processing one character: new state and up to two results.
    typedef struct packed {
        tok_state_t      st;
        logic [1:0]      cnt;
        logic [1:0][7:0] ch;
        logic [1:0]      last;
    } proc_res_t;

    // All results caused by one input byte, in order.
    typedef struct packed {
        logic [1:0]      cnt;
        logic [2:0][7:0] ch;
        logic [2:0]      last;
    } bundle_t;

    // Characters that form a token of their own.
    function automatic logic is_single(logic [7:0] c);
        logic r;
        case (c) inside
            CH_COMMA, CH_SEMI, CH_STAR, CH_LBRACE,
            CH_RBRACE, CH_LBRACK, CH_RBRACK: r = 1'b1;
            default:                         r = 1'b0;
        endcase
        return r;
    endfunction

    // Process one character with an optional successor character.
    function automatic proc_res_t tok_process(tok_state_t st, logic [7:0] cur,
                                              logic has_nxt, logic [7:0] nxt);
        proc_res_t r;
        r     = '0;
        r.st  = st;
        if (st.skip) begin
            r.st.skip = 1'b0;
        end else if (st.in_line) begin
            if (cur == CH_NL) begin
                r.st.in_line = 1'b0;
            end
        end else if (st.in_block) begin
            if (cur == CH_STAR && has_nxt && nxt == CH_SLASH) begin
                r.st.in_block = 1'b0;
                r.st.skip     = 1'b1;
            end
        end else if (cur == CH_SLASH) begin
            // A slash only matters when it opens a comment; otherwise drop it.
            if (has_nxt && (nxt == CH_SLASH || nxt == CH_STAR)) begin
                r.st.in_line  = (nxt == CH_SLASH);
                r.st.in_block = (nxt == CH_STAR);
                r.st.skip     = 1'b1;
                if (st.held_valid) begin
                    r.ch[0]         = st.held_char;
                    r.last[0]       = 1'b1;
                    r.cnt           = 2'd1;
                    r.st.held_valid = 1'b0;
                end
            end
        end else if (cur == CH_SPACE || cur == CH_TAB || cur == CH_NL) begin
            if (st.held_valid) begin
                r.ch[0]         = st.held_char;
                r.last[0]       = 1'b1;
                r.cnt           = 2'd1;
                r.st.held_valid = 1'b0;
            end
        end else if (is_single(cur)) begin
            if (st.held_valid) begin
                r.ch[0]   = st.held_char;
                r.last[0] = 1'b1;
                r.ch[1]   = cur;
                r.last[1] = 1'b1;
                r.cnt     = 2'd2;
            end else begin
                r.ch[0]   = cur;
                r.last[0] = 1'b1;
                r.cnt     = 2'd1;
            end
            r.st.held_valid = 1'b0;
        end else begin
            // Ordinary token character: release the previous one, hold this one.
            if (st.held_valid) begin
                r.ch[0]   = st.held_char;
                r.last[0] = 1'b0;
                r.cnt     = 2'd1;
            end
            r.st.held_char  = cur;
            r.st.held_valid = 1'b1;
        end
        return r;
    endfunction

endpackage

// File: rtl/core/cst_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_front
// Accepts one source byte per cycle while the queue has room, runs the lexer
// state and pushes the results that the byte causes into the queue as one bundle.
// ----------------------------------------------------------------------------
module cst_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_in_byte,
    input  logic             s_end_of_input,
    output logic             push_valid,
    input  logic             push_ready,
    output cst_pkg::bundle_t push_data
);
    import cst_pkg::*;

    tok_state_t st_reg, st_next;
    logic [7:0] la_char_reg, la_char_next;
    logic       la_valid_reg, la_valid_next;

    proc_res_t  r1, r2;
    tok_state_t st_mid;
    bundle_t    bun;
    logic       is_cr;
    logic [7:0] la_mid;
    logic       la_valid_mid;
    logic       accept;

    assign s_ready = push_ready;
    assign accept  = s_valid && push_ready;

    // Two chained character steps, then the end-of-text flush.
    always_comb begin
        is_cr = (s_in_byte == CH_CR);
        bun   = '0;

        // Step on the lookahead byte with the new byte as successor.
        r1    = '0;
        r1.st = st_reg;
        if (!is_cr && la_valid_reg) begin
            r1 = tok_process(st_reg, la_char_reg, 1'b1, s_in_byte);
        end
        st_mid       = r1.st;
        la_mid       = is_cr ? la_char_reg : s_in_byte;
        la_valid_mid = la_valid_reg || !is_cr;

        // At end of text the new lookahead is processed with no successor.
        r2    = '0;
        r2.st = st_mid;
        if (s_end_of_input && la_valid_mid) begin
            r2 = tok_process(st_mid, la_mid, 1'b0, 8'h00);
        end

        // Gather results in order.
        if (r1.cnt != 2'd0) begin
            bun.ch[bun.cnt]   = r1.ch[0];
            bun.last[bun.cnt] = r1.last[0];
            bun.cnt           = bun.cnt + 2'd1;
        end
        if (r1.cnt == 2'd2) begin
            bun.ch[bun.cnt]   = r1.ch[1];
            bun.last[bun.cnt] = r1.last[1];
            bun.cnt           = bun.cnt + 2'd1;
        end
        if (r2.cnt != 2'd0) begin
            bun.ch[bun.cnt]   = r2.ch[0];
            bun.last[bun.cnt] = r2.last[0];
            bun.cnt           = bun.cnt + 2'd1;
        end
        if (r2.cnt == 2'd2) begin
            bun.ch[bun.cnt]   = r2.ch[1];
            bun.last[bun.cnt] = r2.last[1];
            bun.cnt           = bun.cnt + 2'd1;
        end

        st_next       = r2.st;
        la_char_next  = la_mid;
        la_valid_next = la_valid_mid;

        // Flush the held byte and start a fresh text.
        if (s_end_of_input) begin
            if (st_next.held_valid) begin
                bun.ch[bun.cnt]   = st_next.held_char;
                bun.last[bun.cnt] = 1'b1;
                bun.cnt           = bun.cnt + 2'd1;
            end
            st_next.held_valid = 1'b0;
            st_next.in_line    = 1'b0;
            st_next.in_block   = 1'b0;
            st_next.skip       = 1'b0;
            la_char_next       = 8'h00;
            la_valid_next      = 1'b0;
        end
    end

    assign push_data  = bun;
    assign push_valid = accept && (bun.cnt != 2'd0);

    // State advances on every input transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg       <= '0;
            la_char_reg  <= 8'h00;
            la_valid_reg <= 1'b0;
        end else if (accept) begin
            st_reg       <= st_next;
            la_char_reg  <= la_char_next;
            la_valid_reg <= la_valid_next;
        end
    end

endmodule

// File: rtl/core/cst_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_queue
// Small first-in first-out queue of result bundles between the front end and
// the output stage.
// ----------------------------------------------------------------------------
`include "comment_stripping_tokenizer_assert.svh"

module cst_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  cst_pkg::bundle_t push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output cst_pkg::bundle_t pop_data
);
    import cst_pkg::*;

    bundle_t          slots_reg [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]     count_reg, count_next;
    logic             push_fire, pop_fire;

    assign push_ready = (count_reg != (QAW+1)'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slots_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    // Pointer and fill count updates.
    always_comb begin
        wr_ptr_next = push_fire ? wr_ptr_reg + QAW'(1) : wr_ptr_reg;
        rd_ptr_next = pop_fire ? rd_ptr_reg + QAW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push_fire && !pop_fire) begin
            count_next = count_reg + (QAW+1)'(1);
        end else if (pop_fire && !push_fire) begin
            count_next = count_reg - (QAW+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Bundle storage.
    always_ff @(posedge aclk) begin
        if (push_fire) begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

    `CST_ASSERT(a_count_bound, count_reg <= (QAW+1)'(QDEPTH))
    `CST_ASSERT(a_push_nonempty, !push_valid || push_data.cnt != 2'd0)
    `CST_ASSERT_NEXT(a_push_fills, push_fire && !pop_fire, pop_valid)
    `CST_ASSERT_NEXT(a_pop_drains, pop_fire && !push_fire && count_reg == (QAW+1)'(1), !pop_valid)

endmodule

// File: rtl/core/cst_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_back
// Output stage: walks the results of the head bundle one per cycle, while m_ready
// allows, into a registered result channel and releases the bundle after its last result.
// ----------------------------------------------------------------------------
module cst_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    output logic             q_pop,
    input  cst_pkg::bundle_t q_data,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [7:0]       m_out_byte,
    output logic             m_token_last,
    output logic             m_run_last
);
    import cst_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       tlast_reg, tlast_next;
    logic       rlast_reg, rlast_next;
    logic       load;
    logic       is_end;

    assign load   = !valid_reg || m_ready;
    assign is_end = (idx_reg == q_data.cnt - 2'd1);

    // Select the next result of the head bundle.
    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        tlast_next = tlast_reg;
        rlast_next = rlast_reg;
        q_pop      = 1'b0;
        if (load) begin
            valid_next = q_valid;
            if (q_valid) begin
                byte_next  = q_data.ch[idx_reg];
                tlast_next = q_data.last[idx_reg];
                rlast_next = is_end;
                q_pop      = is_end;
                idx_next   = is_end ? 2'd0 : idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg  <= byte_next;
        tlast_reg <= tlast_next;
        rlast_reg <= rlast_next;
    end

    assign m_valid      = valid_reg;
    assign m_out_byte   = byte_reg;
    assign m_token_last = tlast_reg;
    assign m_run_last   = rlast_reg;

endmodule

// File: rtl/core/comment_stripping_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// comment_stripping_tokenizer
// Strips line and block comments and carriage returns from source text and
// emits token bytes, with a flag on the last byte of each token.
// ----------------------------------------------------------------------------
//  channel   direction  ports
//  s_        in         s_valid s_ready s_in_byte s_end_of_input
//  m_        out        m_valid m_ready m_out_byte m_token_last m_run_last
//
//  One byte is taken per cycle while s_ready is high; a byte causes at most
//  three results, which leave one at a time, and a four-bundle result queue
//  absorbs these bursts before s_ready drops.
//  With an empty queue, the first result of a byte passes through the queue
//  slot and then the output register before it is on m_valid.
//  Reset is synchronous; no clearing pass follows.
//  Each side stalls on its own: input waits only on a full queue.
// ----------------------------------------------------------------------------
module comment_stripping_tokenizer (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_end_of_input,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_token_last,
    output logic       m_run_last
);
    import cst_pkg::*;

    logic    push_valid, push_ready;
    bundle_t push_data;
    logic    pop_valid, pop_ready;
    bundle_t pop_data;

    // Lexer front end.
    cst_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_in_byte      (s_in_byte),
        .s_end_of_input (s_end_of_input),
        .push_valid     (push_valid),
        .push_ready     (push_ready),
        .push_data      (push_data)
    );

    // Bundle queue.
    cst_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Result serializer.
    cst_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (pop_valid),
        .q_pop        (pop_ready),
        .q_data       (pop_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_token_last (m_token_last),
        .m_run_last   (m_run_last)
    );

endmodule
